// ----- rtl/sbt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the S-expression byte tokenizer
// Token kinds, error codes, the token and burst records and the character
// constants used by the decoder and the output queue.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_RES    = 6;
  localparam int FRAC_BITS  = 5;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [FRAC_BITS-1:0]  FRAC_MAX  = {FRAC_BITS{1'b1}};

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  typedef enum logic [3:0] {
    TK_LPAREN = 4'd0,
    TK_RPAREN = 4'd1,
    TK_INT    = 4'd2,
    TK_FLOAT  = 4'd3,
    TK_SCHAR  = 4'd4,
    TK_SEND   = 4'd5,
    TK_BOOL   = 4'd6,
    TK_YCHAR  = 4'd7,
    TK_YEND   = 4'd8,
    TK_EOF    = 4'd9,
    TK_ERR    = 4'd10
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_POINTS = 2'd1,
    ERR_ESCAPE = 2'd2,
    ERR_UNTERM = 2'd3
  } err_code_e;

  typedef struct packed {
    token_kind_e             kind;
    logic [7:0]              ch;
    logic [VALUE_BITS-1:0]   value;
    logic [FRAC_BITS-1:0]    frac;
    logic                    bval;
    err_code_e               err;
  } token_t;

  // All tokens caused by one input byte, in emission order.
  typedef struct packed {
    logic [2:0]             n;
    token_t [MAX_RES-1:0]   tok;
  } burst_t;

  function automatic token_t mk_tok(token_kind_e k, logic [7:0] ch,
                                    logic [VALUE_BITS-1:0] v,
                                    logic [FRAC_BITS-1:0] f, logic b,
                                    err_code_e e);
    token_t t;
    t.kind  = k;
    t.ch    = ch;
    t.value = v;
    t.frac  = f;
    t.bval  = b;
    t.err   = e;
    return t;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return is_space(c) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_QUOTE) || (c == CH_NUL);
  endfunction

  // Characters of the words "true" and "false".
  function automatic logic [7:0] pfx_char(logic false_word, logic [2:0] idx);
    logic [7:0] r;
    r = CH_NUL;
    if (false_word) begin
      case (idx)
        3'd0:    r = CH_LOW_F;
        3'd1:    r = CH_LOW_A;
        3'd2:    r = CH_LOW_L;
        3'd3:    r = CH_LOW_S;
        3'd4:    r = CH_LOW_E;
        default: r = CH_NUL;
      endcase
    end else begin
      case (idx)
        3'd0:    r = CH_LOW_T;
        3'd1:    r = CH_LOW_R;
        3'd2:    r = CH_LOW_U;
        3'd3:    r = CH_LOW_E;
        default: r = CH_NUL;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/sbt_decode.sv -----
// ----------------------------------------------------------------------------
// sbt_decode: scanner state and per-byte token decode
// Holds the scan state and turns one byte into a burst of up to six tokens.
// ----------------------------------------------------------------------------
module sbt_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      byte_i,
  input  logic            fire_i,
  output sbt_pkg::burst_t burst_o
);
  import sbt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_STR,
    MODE_ESC,
    MODE_PFX,
    MODE_SYM,
    MODE_ERR
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [2:0]            pcnt_q, pcnt_d;
  logic                  pfalse_q, pfalse_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  point_q, point_d;
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  err_code_e             sticky_q, sticky_d;

  logic [2:0]            n_d;
  logic                  run_st;
  logic                  sym_byte;
  logic [2:0]            plen;
  logic [VALUE_BITS+3:0] acc_x10;
  logic [7:0]            esc_ch;
  logic                  esc_ok;

  assign plen    = pfalse_q ? 3'd5 : 3'd4;
  assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) +
                   {{VALUE_BITS{1'b0}}, byte_i[3:0]};

  always_comb begin
    esc_ok = 1'b1;
    esc_ch = byte_i;
    if (byte_i == CH_LOW_N) begin
      esc_ch = CH_LF;
    end else if (byte_i == CH_LOW_T) begin
      esc_ch = CH_TAB;
    end else if ((byte_i != CH_BSLASH) && (byte_i != CH_QUOTE)) begin
      esc_ok = 1'b0;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pcnt_d   = pcnt_q;
    pfalse_d = pfalse_q;
    acc_d    = acc_q;
    point_d  = point_q;
    frac_d   = frac_q;
    sticky_d = sticky_q;
    burst_o  = '0;
    n_d      = 3'd0;
    run_st   = 1'b0;
    sym_byte = 1'b0;

    case (mode_q)
      MODE_NUM: begin
        if (is_digit(byte_i)) begin
          if (acc_x10 > {4'd0, VALUE_MAX}) begin
            acc_d = VALUE_MAX;
          end else begin
            acc_d = acc_x10[VALUE_BITS-1:0];
          end
          if (point_q && (frac_q != FRAC_MAX)) begin
            frac_d = frac_q + 1'b1;
          end
        end else if (byte_i == CH_DOT) begin
          if (point_q) begin
            sticky_d = ERR_POINTS;
            mode_d   = MODE_ERR;
            burst_o.tok[n_d] = mk_tok(TK_ERR, CH_NUL, '0, '0, 1'b0, ERR_POINTS);
            n_d = n_d + 1'b1;
          end else begin
            point_d = 1'b1;
          end
        end else begin
          if (point_q) begin
            burst_o.tok[n_d] = mk_tok(TK_FLOAT, CH_NUL, acc_q, frac_q, 1'b0,
                                      ERR_NONE);
          end else begin
            burst_o.tok[n_d] = mk_tok(TK_INT, CH_NUL, acc_q, '0, 1'b0, ERR_NONE);
          end
          n_d    = n_d + 1'b1;
          run_st = 1'b1;
        end
      end
      MODE_STR: begin
        if (byte_i == CH_QUOTE) begin
          mode_d = MODE_IDLE;
          burst_o.tok[n_d] = mk_tok(TK_SEND, CH_NUL, '0, '0, 1'b0, ERR_NONE);
          n_d = n_d + 1'b1;
        end else if (byte_i == CH_BSLASH) begin
          mode_d = MODE_ESC;
        end else if (byte_i == CH_NUL) begin
          sticky_d = ERR_UNTERM;
          mode_d   = MODE_ERR;
          burst_o.tok[n_d] = mk_tok(TK_ERR, CH_NUL, '0, '0, 1'b0, ERR_UNTERM);
          n_d = n_d + 1'b1;
        end else begin
          burst_o.tok[n_d] = mk_tok(TK_SCHAR, byte_i, '0, '0, 1'b0, ERR_NONE);
          n_d = n_d + 1'b1;
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_NUL) begin
          sticky_d = ERR_UNTERM;
          mode_d   = MODE_ERR;
          burst_o.tok[n_d] = mk_tok(TK_ERR, CH_NUL, '0, '0, 1'b0, ERR_UNTERM);
          n_d = n_d + 1'b1;
        end else if (!esc_ok) begin
          sticky_d = ERR_ESCAPE;
          mode_d   = MODE_ERR;
          burst_o.tok[n_d] = mk_tok(TK_ERR, CH_NUL, '0, '0, 1'b0, ERR_ESCAPE);
          n_d = n_d + 1'b1;
        end else begin
          mode_d = MODE_STR;
          burst_o.tok[n_d] = mk_tok(TK_SCHAR, esc_ch, '0, '0, 1'b0, ERR_NONE);
          n_d = n_d + 1'b1;
        end
      end
      MODE_PFX: begin
        if ((pcnt_q < plen) && (byte_i == pfx_char(pfalse_q, pcnt_q))) begin
          pcnt_d = pcnt_q + 1'b1;
          if (pcnt_d == plen) begin
            mode_d = MODE_IDLE;
            pcnt_d = 3'd0;
            burst_o.tok[n_d] = mk_tok(TK_BOOL, CH_NUL, '0, '0, !pfalse_q,
                                      ERR_NONE);
            n_d = n_d + 1'b1;
          end
        end else begin
          // Mismatch: the matched part of the word becomes a symbol.
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < pcnt_q) begin
              burst_o.tok[n_d] = mk_tok(TK_YCHAR, pfx_char(pfalse_q, 3'(i)), '0,
                                        '0, 1'b0, ERR_NONE);
              n_d = n_d + 1'b1;
            end
          end
          pcnt_d   = 3'd0;
          sym_byte = 1'b1;
        end
      end
      MODE_SYM: begin
        sym_byte = 1'b1;
      end
      MODE_ERR: begin
        burst_o.tok[n_d] = mk_tok(TK_ERR, CH_NUL, '0, '0, 1'b0, sticky_q);
        n_d = n_d + 1'b1;
      end
      default: begin
        run_st = 1'b1;
      end
    endcase

    if (sym_byte) begin
      if (is_term(byte_i)) begin
        burst_o.tok[n_d] = mk_tok(TK_YEND, CH_NUL, '0, '0, 1'b0, ERR_NONE);
        n_d    = n_d + 1'b1;
        run_st = 1'b1;
      end else begin
        mode_d = MODE_SYM;
        burst_o.tok[n_d] = mk_tok(TK_YCHAR, byte_i, '0, '0, 1'b0, ERR_NONE);
        n_d = n_d + 1'b1;
      end
    end

    // Handling of a byte at the start of a token.
    if (run_st) begin
      mode_d = MODE_IDLE;
      if (byte_i == CH_NUL) begin
        burst_o.tok[n_d] = mk_tok(TK_EOF, CH_NUL, '0, '0, 1'b0, ERR_NONE);
        n_d = n_d + 1'b1;
      end else if (is_space(byte_i)) begin
        mode_d = MODE_IDLE;
      end else if (byte_i == CH_LPAREN) begin
        burst_o.tok[n_d] = mk_tok(TK_LPAREN, CH_NUL, '0, '0, 1'b0, ERR_NONE);
        n_d = n_d + 1'b1;
      end else if (byte_i == CH_RPAREN) begin
        burst_o.tok[n_d] = mk_tok(TK_RPAREN, CH_NUL, '0, '0, 1'b0, ERR_NONE);
        n_d = n_d + 1'b1;
      end else if (is_digit(byte_i)) begin
        mode_d  = MODE_NUM;
        acc_d   = {{(VALUE_BITS-4){1'b0}}, byte_i[3:0]};
        point_d = 1'b0;
        frac_d  = '0;
      end else if (byte_i == CH_QUOTE) begin
        mode_d = MODE_STR;
      end else if ((byte_i == CH_LOW_T) || (byte_i == CH_LOW_F)) begin
        mode_d   = MODE_PFX;
        pcnt_d   = 3'd1;
        pfalse_d = (byte_i == CH_LOW_F);
      end else begin
        mode_d = MODE_SYM;
        burst_o.tok[n_d] = mk_tok(TK_YCHAR, byte_i, '0, '0, 1'b0, ERR_NONE);
        n_d = n_d + 1'b1;
      end
    end

    burst_o.n = n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pcnt_q   <= 3'd0;
      pfalse_q <= 1'b0;
      acc_q    <= '0;
      point_q  <= 1'b0;
      frac_q   <= '0;
      sticky_q <= ERR_NONE;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      pcnt_q   <= pcnt_d;
      pfalse_q <= pfalse_d;
      acc_q    <= acc_d;
      point_q  <= point_d;
      frac_q   <= frac_d;
      sticky_q <= sticky_d;
    end
  end

endmodule

// ----- rtl/sbt_burst_queue.sv -----
// ----------------------------------------------------------------------------
// sbt_burst_queue: two-entry queue of token bursts with output serializer
// Stores whole bursts and hands their tokens out one beat at a time.
// ----------------------------------------------------------------------------
module sbt_burst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbt_pkg::burst_t burst_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sbt_pkg::token_t tok_o,
  output logic            last_o
);
  import sbt_pkg::*;

  burst_t     mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [2:0] idx_q;
  burst_t     head;
  logic       pop;

  assign head        = mem_q[rd_ptr_q];
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign tok_o       = head.tok[idx_q];
  assign last_o      = (idx_q == (head.n - 3'd1));
  assign pop         = out_valid_o && out_ready_i && last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      idx_q    <= 3'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
        idx_q    <= 3'd0;
      end else if (out_valid_o && out_ready_i) begin
        idx_q <= idx_q + 3'd1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("burst pushed into a full queue");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head.n != 3'd0) && (idx_q < head.n))
    else $error("head burst index out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(idx_q) && $stable(rd_ptr_q))
    else $error("head token moved during stall");

endmodule

// ----- rtl/sexpr_byte_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// sexpr_byte_tokenizer_core: S-expression tokenizer, one source byte per beat
// Input register, per-byte decode with scan state, and a burst queue that
// serializes the tokens of each byte onto the result channel.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one source byte per beat on char_byte_i; a zero
// byte ends the text. The result channel gives one token per beat with its
// kind, character, number value, fraction digit count, bool value and error
// code; last_of_run_o marks the final token that one byte caused. A byte can
// cause no token (whitespace, inside a number) or up to six.
// An accepted byte is held in the input register, decoded once the queue has
// room, and its burst is written into the queue, from which its first token
// is offered.
// Throughput: one byte per cycle while each byte causes at most one token and
// the receiver keeps ready high. A byte that causes k tokens occupies the
// result port for k beats; the two-burst queue behind the decoder lets the
// input keep flowing while the receiver drains it.
// Reset returns the scanner to its idle state and clears any sticky error;
// no clearing pass is needed. When the receiver stalls, the queue fills, the
// decoder holds its byte, and in_ready_o drops; nothing is lost.
// ----------------------------------------------------------------------------
module sexpr_byte_tokenizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      char_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      token_kind_o,
  output logic [7:0]                      char_out_o,
  output logic [sbt_pkg::VALUE_BITS-1:0]  number_value_o,
  output logic [sbt_pkg::FRAC_BITS-1:0]   fraction_digits_o,
  output logic                            bool_value_o,
  output logic [1:0]                      error_code_o,
  output logic                            last_of_run_o
);
  import sbt_pkg::*;

  // Input register: one byte waiting for the decoder.
  logic       byte_vld_q;
  logic [7:0] byte_q;

  logic       fire;
  logic       full;
  burst_t     burst;
  token_t     tok;

  // The decoder consumes its byte whenever the queue has room for a burst.
  assign fire       = byte_vld_q && !full;
  assign in_ready_o = !byte_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= char_byte_i;
    end
  end

  sbt_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_q),
    .fire_i  (fire),
    .burst_o (burst)
  );

  // Bytes that cause no token leave nothing in the queue.
  sbt_burst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && (burst.n != 3'd0)),
    .burst_i     (burst),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o      = tok.kind;
  assign char_out_o        = tok.ch;
  assign number_value_o    = tok.value;
  assign fraction_digits_o = tok.frac;
  assign bool_value_o      = tok.bval;
  assign error_code_o      = tok.err;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for sexpr_byte_tokenizer_core
// Feeds source text one byte per beat: a short hand-written text, then a long
// random mix of well-formed tokens and noise, and at the end one error with
// its sticky follow-up. A scoreboard predicts the tokens of every accepted
// byte and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sbt_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUM,
    SCAN_STR,
    SCAN_ESC,
    SCAN_PREFIX,
    SCAN_SYM,
    SCAN_HALT
  } scan_e;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_exp_t;

  // Scoreboard: keeps its own copy of the scanner state, turns each accepted
  // byte into the tokens it should cause, and checks result beats in order.
  class token_tracker;
    scan_e                 mode;
    int                    pfx_len;
    logic                  pfx_false;
    logic [VALUE_BITS-1:0] acc;
    logic                  pt_seen;
    logic [FRAC_BITS-1:0]  frac_cnt;
    err_code_e             sticky;
    int                    mismatches;
    token_exp_t            due_tokens[$];
    token_t                run_q[$];

    function new();
      mode       = SCAN_IDLE;
      pfx_len    = 0;
      pfx_false  = 1'b0;
      acc        = '0;
      pt_seen    = 1'b0;
      frac_cnt   = '0;
      sticky     = ERR_NONE;
      mismatches = 0;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    static function bit is_numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    static function bit ends_symbol(logic [7:0] c);
      return is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE ||
             c == CH_NUL;
    endfunction

    static function logic [7:0] word_char(logic false_word, int idx);
      string w;
      w = false_word ? "false" : "true";
      return w[idx];
    endfunction

    function int due();
      return due_tokens.size();
    endfunction

    // True when this byte would drive the scanner into its error state.
    function bit would_fault(logic [7:0] c);
      return (mode == SCAN_NUM && c == CH_DOT && pt_seen) ||
             (mode == SCAN_STR && c == CH_NUL) ||
             (mode == SCAN_ESC && !(c == CH_LOW_N || c == CH_LOW_T ||
                                    c == CH_BSLASH || c == CH_QUOTE));
    endfunction

    function void push(token_kind_e k, logic [7:0] ch, logic [VALUE_BITS-1:0] v,
                       logic [FRAC_BITS-1:0] f, logic b, err_code_e e);
      token_t t;
      t.kind  = k;
      t.ch    = ch;
      t.value = v;
      t.frac  = f;
      t.bval  = b;
      t.err   = e;
      run_q.push_back(t);
    endfunction

    function void fault(err_code_e e);
      sticky = e;
      mode   = SCAN_HALT;
      push(TK_ERR, 8'h00, '0, '0, 1'b0, sticky);
    endfunction

    function void begin_token(logic [7:0] c);
      mode = SCAN_IDLE;
      if (c == CH_NUL) begin
        push(TK_EOF, 8'h00, '0, '0, 1'b0, ERR_NONE);
      end else if (is_blank(c)) begin
        // Whitespace between tokens causes nothing.
      end else if (c == CH_LPAREN) begin
        push(TK_LPAREN, 8'h00, '0, '0, 1'b0, ERR_NONE);
      end else if (c == CH_RPAREN) begin
        push(TK_RPAREN, 8'h00, '0, '0, 1'b0, ERR_NONE);
      end else if (is_numeral(c)) begin
        mode     = SCAN_NUM;
        acc      = VALUE_BITS'(c - CH_ZERO);
        pt_seen  = 1'b0;
        frac_cnt = '0;
      end else if (c == CH_QUOTE) begin
        mode = SCAN_STR;
      end else if (c == CH_LOW_T || c == CH_LOW_F) begin
        mode      = SCAN_PREFIX;
        pfx_len   = 1;
        pfx_false = (c == CH_LOW_F);
      end else begin
        mode = SCAN_SYM;
        push(TK_YCHAR, c, '0, '0, 1'b0, ERR_NONE);
      end
    endfunction

    function void sym_byte(logic [7:0] c);
      if (ends_symbol(c)) begin
        push(TK_YEND, 8'h00, '0, '0, 1'b0, ERR_NONE);
        begin_token(c);
      end else begin
        mode = SCAN_SYM;
        push(TK_YCHAR, c, '0, '0, 1'b0, ERR_NONE);
      end
    endfunction

    // Advances the predicted scanner by one accepted byte and queues the
    // tokens it causes, the last one marked as the end of the run.
    function void predict_byte(logic [7:0] c);
      longint unsigned wide_acc;
      longint unsigned digit;
      longint unsigned top;
      int              word_len;
      run_q.delete();
      case (mode)
        SCAN_NUM: begin
          if (is_numeral(c)) begin
            wide_acc = acc;
            digit    = c - CH_ZERO;
            top      = VALUE_MAX;
            // Saturate instead of wrapping once the value would overflow.
            if (wide_acc > (top - digit) / 10) acc = VALUE_MAX;
            else acc = VALUE_BITS'(wide_acc * 10 + digit);
            if (pt_seen && frac_cnt != FRAC_MAX) frac_cnt++;
          end else if (c == CH_DOT) begin
            if (pt_seen) fault(ERR_POINTS);
            else pt_seen = 1'b1;
          end else begin
            if (pt_seen) push(TK_FLOAT, 8'h00, acc, frac_cnt, 1'b0, ERR_NONE);
            else push(TK_INT, 8'h00, acc, '0, 1'b0, ERR_NONE);
            begin_token(c);
          end
        end
        SCAN_STR: begin
          if (c == CH_QUOTE) begin
            mode = SCAN_IDLE;
            push(TK_SEND, 8'h00, '0, '0, 1'b0, ERR_NONE);
          end else if (c == CH_BSLASH) begin
            mode = SCAN_ESC;
          end else if (c == CH_NUL) begin
            fault(ERR_UNTERM);
          end else begin
            push(TK_SCHAR, c, '0, '0, 1'b0, ERR_NONE);
          end
        end
        SCAN_ESC: begin
          // An escaped backslash is a plain character, so the quote after it
          // still closes the string.
          if (c == CH_NUL) begin
            fault(ERR_UNTERM);
          end else if (c == CH_LOW_N) begin
            mode = SCAN_STR;
            push(TK_SCHAR, CH_LF, '0, '0, 1'b0, ERR_NONE);
          end else if (c == CH_LOW_T) begin
            mode = SCAN_STR;
            push(TK_SCHAR, CH_TAB, '0, '0, 1'b0, ERR_NONE);
          end else if (c == CH_BSLASH || c == CH_QUOTE) begin
            mode = SCAN_STR;
            push(TK_SCHAR, c, '0, '0, 1'b0, ERR_NONE);
          end else begin
            fault(ERR_ESCAPE);
          end
        end
        SCAN_PREFIX: begin
          word_len = pfx_false ? 5 : 4;
          if (c == word_char(pfx_false, pfx_len)) begin
            pfx_len++;
            if (pfx_len == word_len) begin
              mode    = SCAN_IDLE;
              pfx_len = 0;
              push(TK_BOOL, 8'h00, '0, '0, !pfx_false, ERR_NONE);
            end
          end else begin
            // A broken bool word is replayed as the start of a symbol.
            for (int i = 0; i < pfx_len; i++)
              push(TK_YCHAR, word_char(pfx_false, i), '0, '0, 1'b0, ERR_NONE);
            pfx_len = 0;
            sym_byte(c);
          end
        end
        SCAN_SYM:  sym_byte(c);
        SCAN_HALT: push(TK_ERR, 8'h00, '0, '0, 1'b0, sticky);
        default:   begin_token(c);
      endcase
      foreach (run_q[i])
        due_tokens.push_back('{tok: run_q[i], last: (i == run_q.size() - 1)});
    endfunction

    function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v,
               got_v);
    endfunction

    function void check_token(token_t got, logic got_last);
      token_exp_t want;
      if (due_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token, expected none, actual kind %0h", $time,
                 got.kind);
        return;
      end
      want = due_tokens.pop_front();
      if (got.kind !== want.tok.kind)   report("token_kind", want.tok.kind, got.kind);
      if (got.ch !== want.tok.ch)       report("char_out", want.tok.ch, got.ch);
      if (got.value !== want.tok.value) report("number_value", want.tok.value, got.value);
      if (got.frac !== want.tok.frac)   report("fraction_digits", want.tok.frac, got.frac);
      if (got.bval !== want.tok.bval)   report("bool_value", want.tok.bval, got.bval);
      if (got.err !== want.tok.err)     report("error_code", want.tok.err, got.err);
      if (got_last !== want.last)       report("last_of_run", want.last, got_last);
    endfunction
  endclass

  localparam int QUIET_LIMIT = 2000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            char_byte_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [3:0]            token_kind_o;
  logic [7:0]            char_out_o;
  logic [VALUE_BITS-1:0] number_value_o;
  logic [FRAC_BITS-1:0]  fraction_digits_o;
  logic                  bool_value_o;
  logic [1:0]            error_code_o;
  logic                  last_of_run_o;

  token_tracker sb = new();
  bit           no_idle   = 1'b0;
  int           next_gap  = 0;
  int           fed       = 0;
  int           quiet     = 0;

  sexpr_byte_tokenizer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_byte_i      (char_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_o     (token_kind_o),
    .char_out_o       (char_out_o),
    .number_value_o   (number_value_o),
    .fraction_digits_o(fraction_digits_o),
    .bool_value_o     (bool_value_o),
    .error_code_o     (error_code_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One source byte per beat. Handshake values are sampled at the falling
  // edge, where they equal what the next rising edge sees.
  task automatic put(input logic [7:0] b);
    bit took;
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    sb.predict_byte(b);
    fed++;
    next_gap = no_idle ? 0 : $urandom_range(0, 18);
    if (next_gap > 0) in_valid_i <= 1'b0;
  endtask

  // Lowers valid for a pause of unknown length.
  task automatic hold_input();
    if (next_gap == 0) in_valid_i <= 1'b0;
    next_gap = 1;
  endtask

  // Like put, but swaps a byte that would cause an error for a harmless one,
  // since after an error every byte gives only an error token until reset.
  task automatic put_safe(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (sb.would_fault(b)) begin
      case (sb.mode)
        SCAN_NUM: c = CH_SPACE;
        SCAN_STR: c = "z";
        default:  c = CH_BSLASH;
      endcase
    end
    put(c);
  endtask

  // Closes an open string, and with to_idle also any other open token.
  task automatic settle(input bit to_idle);
    while (sb.mode == SCAN_STR || sb.mode == SCAN_ESC ||
           (to_idle && sb.mode != SCAN_IDLE)) begin
      case (sb.mode)
        SCAN_STR: put(CH_QUOTE);
        SCAN_ESC: put(CH_LOW_N);
        default:  put(CH_SPACE);
      endcase
    end
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_ender();
    case ($urandom_range(0, 7))
      0:       return CH_SPACE;
      1:       return 8'($urandom_range(CH_TAB, CH_CR));
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_NUL;
      5:       return CH_QUOTE;
      default: return "q";
    endcase
  endfunction

  function automatic logic [7:0] rand_sym_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (token_tracker::ends_symbol(c));
    return c;
  endfunction

  task automatic gen_number();
    int ndig;
    int nfrac;
    // Mostly short numbers; now and then long enough to saturate.
    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
    repeat (ndig) put_safe(rand_digit());
    if ($urandom_range(0, 2) == 0) begin
      put_safe(CH_DOT);
      nfrac = ($urandom_range(0, 24) == 0) ? $urandom_range(31, 34) : $urandom_range(0, 3);
      repeat (nfrac) put_safe(rand_digit());
    end
    put_safe(rand_ender());
  endtask

  task automatic gen_string();
    logic [7:0] c;
    put_safe(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 4) == 0) begin
        put_safe(CH_BSLASH);
        case ($urandom_range(0, 3))
          0:       put_safe(CH_LOW_N);
          1:       put_safe(CH_LOW_T);
          2:       put_safe(CH_BSLASH);
          default: put_safe(CH_QUOTE);
        endcase
      end else begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        put_safe(c);
      end
    end
    put_safe(CH_QUOTE);
  endtask

  task automatic gen_bool();
    logic       false_word;
    int         word_len;
    int         keep;
    logic [7:0] c;
    false_word = $urandom_range(0, 1);
    word_len   = false_word ? 5 : 4;
    keep       = $urandom_range(0, 1) ? word_len : $urandom_range(1, word_len - 1);
    for (int i = 0; i < keep; i++) put_safe(token_tracker::word_char(false_word, i));
    if (keep < word_len) begin
      // Break the word with any byte but the one it needs.
      do c = 8'($urandom_range(0, 255));
      while (c == token_tracker::word_char(false_word, keep));
      put_safe(c);
    end else if ($urandom_range(0, 2) == 0) begin
      put_safe("x");
    end
  endtask

  task automatic gen_symbol();
    logic [7:0] c;
    do c = rand_sym_char();
    while (token_tracker::is_numeral(c) || c == CH_LOW_T || c == CH_LOW_F);
    put_safe(c);
    repeat ($urandom_range(0, 5)) put_safe(rand_sym_char());
    put_safe(rand_ender());
  endtask

  // Receiver: holds ready low for a random stall before each result beat, unless no_idle is set.
  initial begin
    token_t got;
    logic   got_last;
    int     stall;
    bit     took;
    stall = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall > 0) repeat (stall) @(posedge clk_i);
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took      = out_valid_o;
        got.kind  = token_kind_e'(token_kind_o);
        got.ch    = char_out_o;
        got.value = number_value_o;
        got.frac  = fraction_digits_o;
        got.bval  = bool_value_o;
        got.err   = err_code_e'(error_code_o);
        got_last  = last_of_run_o;
        @(posedge clk_i);
      end while (!took);
      sb.check_token(got, got_last);
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall > 0) out_ready_i <= 1'b0;
    end
  end

  initial begin
    logic [7:0] intro[$];
    bit         pressed;
    pressed = 1'b0;
    // Parens, an integer ended by a paren, a float with a trailing point, a
    // full bool followed by a symbol char, a broken "false" replayed before a
    // paren, a string with a high byte and an escaped backslash before its
    // closing quote, then end of text.
    intro = '{CH_LPAREN, "4", "2", CH_RPAREN, "3", CH_DOT, CH_TAB,
              CH_LOW_T, CH_LOW_R, CH_LOW_U, CH_LOW_E, "x", CH_SPACE,
              CH_LOW_F, CH_LOW_A, CH_LOW_L, CH_RPAREN,
              CH_QUOTE, 8'hFF, CH_BSLASH, CH_BSLASH, CH_QUOTE, CH_CR, CH_NUL};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (intro[i]) put(intro[i]);

    while (fed < 330) begin
      no_idle = (fed >= 110 && fed < 200);
      if (!pressed && fed >= 250) begin
        // Let the result side drain completely before going on.
        pressed = 1'b1;
        hold_input();
        while (sb.due() > 0) @(posedge clk_i);
      end
      settle(1'b0);
      case ($urandom_range(0, 9))
        0, 1:    gen_number();
        2, 3:    gen_string();
        4:       gen_bool();
        5:       gen_symbol();
        6:       put_safe($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        7:       put_safe(8'($urandom_range(0, 5) == 0 ? CH_SPACE
                                                     : $urandom_range(CH_TAB, CH_CR)));
        8:       put_safe(CH_NUL);
        default: put_safe(8'($urandom_range(0, 255)));
      endcase
    end

    // An error is sticky until reset, so exactly one kind is hit, at the end.
    no_idle = 1'b0;
    settle(1'b1);
    case (err_code_e'($urandom_range(1, 3)))
      ERR_POINTS: begin
        put(rand_digit());
        put(CH_DOT);
        put(rand_digit());
        put(CH_DOT);
      end
      ERR_ESCAPE: begin
        logic [7:0] c;
        put(CH_QUOTE);
        put("a");
        put(CH_BSLASH);
        do c = 8'($urandom_range(1, 255));
        while (c == CH_LOW_N || c == CH_LOW_T || c == CH_BSLASH || c == CH_QUOTE);
        put(c);
      end
      default: begin
        put(CH_QUOTE);
        put("a");
        if ($urandom_range(0, 1)) put(CH_BSLASH);
        put(CH_NUL);
      end
    endcase
    repeat (5) put(8'($urandom_range(0, 255)));
    put(CH_NUL);

    hold_input();
    while (sb.due() > 0) @(posedge clk_i);
    // Give any surplus token time to show up past the longest stall.
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
